### rtl/mnc_pkg.sv
`timescale 1ns / 1ps

package mnc_pkg;

  localparam int NUM_CENTERS = 16;
  localparam int COORD_WIDTH = 32;

  // fixed field widths of the channels
  localparam int MODE_W  = 1;
  localparam int INDEX_W = 4;
  localparam int FIELD_W = 32;
  localparam int DIST_W  = 33;

  localparam int IDX_W  = $clog2(NUM_CENTERS);
  localparam int LEAVES = 1 << IDX_W;
  localparam int SUM_W  = COORD_WIDTH + 1;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [INDEX_W-1:0]     index_t;
  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [DIST_W-1:0]      dist_t;

  localparam logic [MODE_W-1:0] MODE_LOAD     = 1'b0;
  localparam logic [MODE_W-1:0] MODE_CLASSIFY = 1'b1;

  // low COORD_WIDTH bits of an input field
  function automatic coord_t to_coord(field_t f);
    logic [FIELD_W+COORD_WIDTH-1:0] w;
    w = {{COORD_WIDTH{1'b0}}, f};
    return w[COORD_WIDTH-1:0];
  endfunction

  // offset binary: unsigned compare/subtract match signed
  function automatic coord_t bias(coord_t c);
    return {~c[COORD_WIDTH-1], c[COORD_WIDTH-2:0]};
  endfunction

  function automatic dist_t to_dist(sum_t s);
    logic [SUM_W+DIST_W-1:0] w;
    w = {{DIST_W{1'b0}}, s};
    return w[DIST_W-1:0];
  endfunction

  function automatic index_t to_index(idx_t i);
    logic [IDX_W+INDEX_W-1:0] w;
    w = {{INDEX_W{1'b0}}, i};
    return w[INDEX_W-1:0];
  endfunction

endpackage

### rtl/mnc_in_if.sv
`timescale 1ns / 1ps

interface mnc_in_if;
  logic                        valid;
  logic                        ready;
  logic [mnc_pkg::MODE_W-1:0]  mode;
  logic [mnc_pkg::INDEX_W-1:0] center_index;
  logic signed [mnc_pkg::FIELD_W-1:0] point_x;
  logic signed [mnc_pkg::FIELD_W-1:0] point_y;

  modport source (output valid, mode, center_index, point_x, point_y, input ready);
  modport sink   (input valid, mode, center_index, point_x, point_y, output ready);
endinterface

### rtl/mnc_out_if.sv
`timescale 1ns / 1ps

interface mnc_out_if;
  logic                        valid;
  logic                        ready;
  logic [mnc_pkg::INDEX_W-1:0] cluster_id;
  logic [mnc_pkg::DIST_W-1:0]  min_distance;

  modport source (output valid, cluster_id, min_distance, input ready);
  modport sink   (input valid, cluster_id, min_distance, output ready);
endinterface

### rtl/mnc_center_table.sv
`timescale 1ns / 1ps

module mnc_center_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  mnc_pkg::index_t wr_index,
  input  mnc_pkg::coord_t wr_x,
  input  mnc_pkg::coord_t wr_y,
  output mnc_pkg::coord_t center_x [mnc_pkg::NUM_CENTERS],
  output mnc_pkg::coord_t center_y [mnc_pkg::NUM_CENTERS]
);

  // out-of-range indexes match no entry and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < mnc_pkg::NUM_CENTERS; j++) begin
        center_x[j] <= '0;
        center_y[j] <= '0;
      end
    end else if (wr_en) begin
      for (int j = 0; j < mnc_pkg::NUM_CENTERS; j++) begin
        if (int'(wr_index) == j) begin
          center_x[j] <= wr_x;
          center_y[j] <= wr_y;
        end
      end
    end
  end

endmodule

### rtl/mnc_distance.sv
`timescale 1ns / 1ps

module mnc_distance (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mnc_pkg::coord_t in_x,
  input  mnc_pkg::coord_t in_y,
  input  mnc_pkg::coord_t center_x [mnc_pkg::NUM_CENTERS],
  input  mnc_pkg::coord_t center_y [mnc_pkg::NUM_CENTERS],
  output logic            out_valid,
  input  logic            out_ready,
  output mnc_pkg::sum_t   out_dist [mnc_pkg::NUM_CENTERS]
);

  localparam int W = mnc_pkg::COORD_WIDTH;

  function automatic mnc_pkg::coord_t abs_diff(mnc_pkg::coord_t a, mnc_pkg::coord_t b);
    logic [W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[W] ? (~d[W-1:0] + 1'b1) : d[W-1:0];
  endfunction

  logic            v1, v2, v3;
  logic            take1, take2, take3;
  mnc_pkg::coord_t px, py;
  mnc_pkg::coord_t adx [mnc_pkg::NUM_CENTERS];
  mnc_pkg::coord_t ady [mnc_pkg::NUM_CENTERS];

  assign take3    = !v3 || out_ready;
  assign take2    = !v2 || take3;
  assign take1    = !v1 || take2;
  assign in_ready = take1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (take1) v1 <= in_valid;
      if (take2) v2 <= v1;
      if (take3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      px <= mnc_pkg::bias(in_x);
      py <= mnc_pkg::bias(in_y);
    end
    // centers are read here, so a load ahead of this point is already visible
    if (take2) begin
      for (int j = 0; j < mnc_pkg::NUM_CENTERS; j++) begin
        adx[j] <= abs_diff(px, mnc_pkg::bias(center_x[j]));
        ady[j] <= abs_diff(py, mnc_pkg::bias(center_y[j]));
      end
    end
    if (take3) begin
      for (int j = 0; j < mnc_pkg::NUM_CENTERS; j++) begin
        out_dist[j] <= {1'b0, adx[j]} + {1'b0, ady[j]};
      end
    end
  end

endmodule

### rtl/mnc_argmin.sv
`timescale 1ns / 1ps

module mnc_argmin (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mnc_pkg::sum_t in_dist [mnc_pkg::NUM_CENTERS],
  output logic          out_valid,
  input  logic          out_ready,
  output mnc_pkg::idx_t out_id,
  output mnc_pkg::sum_t out_dist
);

  localparam int LV = mnc_pkg::IDX_W;
  localparam int NL = mnc_pkg::LEAVES;

  logic [LV:1]   vld;
  logic [LV:0]   vchain;
  logic [LV+1:1] take;

  mnc_pkg::sum_t tr_d [1:LV][NL];
  mnc_pkg::idx_t tr_i [1:LV][NL];
  mnc_pkg::sum_t nd   [LV+1][NL];
  mnc_pkg::idx_t ni   [LV+1][NL];

  assign vchain = {vld, in_valid};
  assign take[LV+1] = out_ready;

  genvar g;
  generate
    for (g = 1; g <= LV; g++) begin : g_take
      assign take[g] = !vld[g] || take[g+1];
    end
  endgenerate

  assign in_ready = take[1];

  // padding leaves hold all ones, above any real distance; they sit to the right
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      nd[0][k] = (k < mnc_pkg::NUM_CENTERS) ? in_dist[k % mnc_pkg::NUM_CENTERS] : '1;
      ni[0][k] = LV'(k);
    end
    for (int l = 1; l <= LV; l++) begin
      for (int k = 0; k < NL; k++) begin
        nd[l][k] = tr_d[l][k];
        ni[l][k] = tr_i[l][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int l = 1; l <= LV; l++) begin
        if (take[l]) vld[l] <= vchain[l-1];
      end
    end
  end

  // strict compare keeps the left (lower index) node on ties
  always_ff @(posedge clk) begin
    for (int l = 1; l <= LV; l++) begin
      if (take[l]) begin
        for (int k = 0; k < (NL >> l); k++) begin
          if (nd[l-1][2*k+1] < nd[l-1][2*k]) begin
            tr_d[l][k] <= nd[l-1][2*k+1];
            tr_i[l][k] <= ni[l-1][2*k+1];
          end else begin
            tr_d[l][k] <= nd[l-1][2*k];
            tr_i[l][k] <= ni[l-1][2*k];
          end
        end
      end
    end
  end

  assign out_valid = vld[LV];
  assign out_id    = tr_i[LV][0];
  assign out_dist  = tr_d[LV][0];

endmodule

### rtl/manhattan_nearest_center_unit.sv
`timescale 1ns / 1ps

// Nearest-center classifier under the L1 metric. A load transaction (mode 0)
// writes one center of the 16-entry table and returns nothing; an index past
// the table is dropped. A classify transaction (mode 1) returns the index of
// the center at the least |dx| + |dy| from the point, lowest index on ties,
// with that distance. One transaction is taken per cycle, loads and
// classifies alike, unless the first stage is stalled; a classify result
// passes the point register, absolute differences, sum, then each level of
// the 4-level compare tree. A load is seen by every classify accepted after
// it. Centers reset to (0, 0). Backpressure on the result side stalls the
// pipeline stage by stage; empty stages still fill while it is stalled.
module manhattan_nearest_center_unit (
  input logic       clk,
  input logic       rst,
  mnc_in_if.sink    req,
  mnc_out_if.source rsp
);

  logic            accept;
  logic            dist_ready;
  logic            dist_valid;
  logic            tree_ready;
  mnc_pkg::coord_t cx [mnc_pkg::NUM_CENTERS];
  mnc_pkg::coord_t cy [mnc_pkg::NUM_CENTERS];
  mnc_pkg::sum_t   center_dist [mnc_pkg::NUM_CENTERS];
  mnc_pkg::idx_t   best_id;
  mnc_pkg::sum_t   best_dist;

  assign req.ready = dist_ready;
  assign accept    = req.valid && dist_ready;

  mnc_center_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && (req.mode == mnc_pkg::MODE_LOAD)),
    .wr_index (req.center_index),
    .wr_x     (mnc_pkg::to_coord(req.point_x)),
    .wr_y     (mnc_pkg::to_coord(req.point_y)),
    .center_x (cx),
    .center_y (cy)
  );

  mnc_distance u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid && (req.mode == mnc_pkg::MODE_CLASSIFY)),
    .in_ready  (dist_ready),
    .in_x      (mnc_pkg::to_coord(req.point_x)),
    .in_y      (mnc_pkg::to_coord(req.point_y)),
    .center_x  (cx),
    .center_y  (cy),
    .out_valid (dist_valid),
    .out_ready (tree_ready),
    .out_dist  (center_dist)
  );

  mnc_argmin u_argmin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dist_valid),
    .in_ready  (tree_ready),
    .in_dist   (center_dist),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_id    (best_id),
    .out_dist  (best_dist)
  );

  assign rsp.cluster_id   = mnc_pkg::to_index(best_id);
  assign rsp.min_distance = mnc_pkg::to_dist(best_dist);

endmodule
